FILE: hdl/sspg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine sample packet generator package
// Configuration register codes, shared types and the quarter-wave sine
// table builder that is evaluated at elaboration.
// ----------------------------------------------------------------------------
package sspg_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int SPP_W      = 11;
	localparam int PERIOD_W   = 16;
	localparam int PHASE_W    = 16;
	localparam int PACKET_W   = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PACKET = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SAMPLES     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP         = 8'd2;

	localparam logic [SPP_W-1:0]    SPP_RESET    = 11'd256;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20;
	localparam logic [PHASE_W-1:0]  STEP_RESET   = 16'd3277;

	// Half pi in Q30.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int TAYLOR_TERMS = 10;

	typedef struct packed {
		logic [SPP_W-1:0]    samples_per_packet;
		logic [PERIOD_W-1:0] period_samples;
		logic [PHASE_W-1:0]  phase_step;
	} cfg_t;

	// Restoring division, used only while the table is built.
	function automatic longint unsigned sspg_udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// One quarter-wave entry: integer Taylor series in Q30 with truncating
	// products, clamped and scaled to the full-scale amplitude.
	function automatic longint unsigned sspg_qsin(input int unsigned k,
		input int unsigned tb, input int unsigned sb);
		longint unsigned x;
		longint unsigned term;
		longint unsigned amp;
		longint unsigned v;
		longint unsigned den;
		longint sum;
		amp  = (64'd1 << (sb - 1)) - 64'd1;
		x    = (HALF_PI_Q30 * longint'(k)) >> tb;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			den  = longint'(2 * n) * longint'(2 * n + 1);
			term = sspg_udiv(term, den);
			if ((n % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		v = ((longint'(sum) * amp) + (64'd1 << 29)) >> 30;
		if (v > amp) begin
			v = amp;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/sspg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine sample packet generator channels
// Tick request channel, sample result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface sspg_tick_if;
	logic valid;
	logic ready;
	logic tick;
	modport source(output valid, output tick, input ready);
	modport sink(input valid, input tick, output ready);
endinterface

interface sspg_sample_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int IDX_W       = 10
);
	logic                   valid;
	logic                   ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic [31:0]            packet_number;
	logic [IDX_W-1:0]       index_in_packet;
	logic                   packet_last;
	modport source(output valid, output sample_value, output packet_number,
		output index_in_packet, output packet_last, input ready);
	modport sink(input valid, input sample_value, input packet_number,
		input index_in_packet, input packet_last, output ready);
endinterface

interface sspg_cfg_if import sspg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/sspg_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine sample packet generator configuration registers
// Holds packet size, period and phase step; writes to unknown indexes are
// dropped.
// ----------------------------------------------------------------------------
module sspg_cfg import sspg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sspg_cfg_if.sink   cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.samples_per_packet <= SPP_RESET;
			regs_q.period_samples     <= PERIOD_RESET;
			regs_q.phase_step         <= STEP_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SAMPLES_PER_PACKET: regs_q.samples_per_packet <= cfg.data[SPP_W-1:0];
				CFG_PERIOD_SAMPLES:     regs_q.period_samples     <= cfg.data[PERIOD_W-1:0];
				CFG_PHASE_STEP:         regs_q.phase_step         <= cfg.data[PHASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sspg_sine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine sample packet generator sine lookup
// Quarter-wave table with mirroring and negation by quadrant.
// ----------------------------------------------------------------------------
module sspg_sine import sspg_pkg::*; #(
	parameter int SINE_TABLE_BITS = 8,
	parameter int SAMPLE_BITS     = 16
) (
	input  wire logic [PHASE_W-1:0]          phase,
	output logic signed [SAMPLE_BITS-1:0]    value
);

	localparam int N = 1 << SINE_TABLE_BITS;

	logic [SAMPLE_BITS-2:0]     qtab [0:N];
	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [SINE_TABLE_BITS:0]   sel;
	logic [SAMPLE_BITS-1:0]     mag;

	for (genvar k = 0; k <= N; k++) begin : g_tab
		localparam logic [SAMPLE_BITS-2:0] ENTRY =
			(SAMPLE_BITS-1)'(sspg_qsin(k, SINE_TABLE_BITS, SAMPLE_BITS));
		assign qtab[k] = ENTRY;
	end

	always_comb begin
		quad = phase[PHASE_W-1 -: 2];
		idx  = phase[PHASE_W-3 -: SINE_TABLE_BITS];
		if (quad[0]) begin
			sel = (SINE_TABLE_BITS+1)'(N) - {1'b0, idx};
		end else begin
			sel = {1'b0, idx};
		end
		mag = {1'b0, qtab[sel]};
		if (quad[1]) begin
			value = $signed(-mag);
		end else begin
			value = $signed(mag);
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sine_sample_packet_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine sample packet generator core
// Phase accumulator sine source with packet numbering and packet framing.
// ----------------------------------------------------------------------------
// Each accepted item with tick high yields one sample in the next cycle, and a
// new item is taken in every cycle while the result register is empty or being
// emptied, so the sustained rate is one sample per clock. The per-item path is
// the counter compares plus one quarter-wave table read and negation, between
// the state registers and the result register. An item with tick low is taken
// and produces no sample. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module sine_sample_packet_generator_core import sspg_pkg::*; #(
	parameter int MAX_PACKET_SAMPLES = 1024,
	parameter int SINE_TABLE_BITS    = 8,
	parameter int SAMPLE_BITS        = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sspg_cfg_if.sink     cfg,
	sspg_tick_if.sink    tick_ch,
	sspg_sample_if.source sample_ch
);

	localparam int IDX_W  = (MAX_PACKET_SAMPLES > 1) ? $clog2(MAX_PACKET_SAMPLES) : 1;
	localparam int CW_RAW = $clog2(MAX_PACKET_SAMPLES + 1);
	localparam int CW     = (CW_RAW > SPP_W) ? CW_RAW : SPP_W;

	cfg_t regs;

	logic [PACKET_W-1:0] pkt_q;
	logic [IDX_W-1:0]    pos_q;
	logic [PERIOD_W-1:0] per_pos_q;
	logic [PHASE_W-1:0]  phase_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [PACKET_W-1:0]           pkt_out_q;
	logic [IDX_W-1:0]              idx_out_q;
	logic                          last_out_q;

	logic                          in_fire;
	logic                          go;
	logic [CW-1:0]                 spp_ext;
	logic [CW-1:0]                 spp_eff;
	logic [PERIOD_W-1:0]           per_eff;
	logic                          last_c;
	logic                          per_wrap;
	logic signed [SAMPLE_BITS-1:0] sine_c;

	sspg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sspg_sine #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_sine (
		.phase (phase_q),
		.value (sine_c)
	);

	assign tick_ch.ready = !out_valid_q || sample_ch.ready;
	assign in_fire       = tick_ch.valid && tick_ch.ready;
	assign go            = in_fire && tick_ch.tick;

	always_comb begin
		spp_ext = CW'(regs.samples_per_packet);
		if (spp_ext == '0) begin
			spp_eff = CW'(1);
		end else if (spp_ext > CW'(MAX_PACKET_SAMPLES)) begin
			spp_eff = CW'(MAX_PACKET_SAMPLES);
		end else begin
			spp_eff = spp_ext;
		end
		if (regs.period_samples == '0) begin
			per_eff = PERIOD_W'(1);
		end else begin
			per_eff = regs.period_samples;
		end
		last_c   = (CW'(pos_q) + CW'(1)) >= spp_eff;
		per_wrap = ({1'b0, per_pos_q} + 17'd1) >= {1'b0, per_eff};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q       <= '0;
			pos_q       <= '0;
			per_pos_q   <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				out_valid_q <= 1'b1;
				if (last_c) begin
					pos_q <= '0;
					pkt_q <= pkt_q + 32'd1;
				end else begin
					pos_q <= pos_q + IDX_W'(1);
				end
				if (per_wrap) begin
					per_pos_q <= '0;
					phase_q   <= '0;
				end else begin
					per_pos_q <= per_pos_q + 16'd1;
					phase_q   <= phase_q + regs.phase_step;
				end
			end else if (sample_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sample_q   <= sine_c;
			pkt_out_q  <= pkt_q;
			idx_out_q  <= pos_q;
			last_out_q <= last_c;
		end
	end

	assign sample_ch.valid           = out_valid_q;
	assign sample_ch.sample_value    = sample_q;
	assign sample_ch.packet_number   = pkt_out_q;
	assign sample_ch.index_in_packet = idx_out_q;
	assign sample_ch.packet_last     = last_out_q;

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !sample_ch.ready |=> out_valid_q)
		else $error("result dropped while stalled");

	a_packet_advance: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_c |=> pkt_q == $past(pkt_q) + 32'd1 && pos_q == '0)
		else $error("packet counter did not advance at end of packet");

	a_phase_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		go && per_wrap |=> phase_q == '0 && per_pos_q == '0)
		else $error("phase did not return to zero at period wrap");

	a_idle_state: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(pkt_q) && $stable(pos_q) && $stable(phase_q))
		else $error("state changed without a tick");

endmodule
`default_nettype wire
